>>> rtl/core/keyframe_timeline_advance_assert.svh
// Assertion macros for the keyframe timeline block
`ifndef KEYFRAME_TIMELINE_ADVANCE_ASSERT_SVH
`define KEYFRAME_TIMELINE_ADVANCE_ASSERT_SVH

// same-cycle implication
`define KTA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kta assertion failed");

// next-cycle implication
`define KTA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kta assertion failed");

`endif

>>> rtl/core/kta_pkg.sv
package kta_pkg;
	localparam int MAX_FRAMES = 64;
	localparam int IDX_W      = $clog2(MAX_FRAMES);
	localparam int CNT_W      = 7;
	localparam int TIME_W     = 32;
	localparam int FRAC_W     = 17;
	localparam int FRAC_ONE   = 65536;
	localparam int DIV_W      = 48;
	localparam int DIVC_W     = $clog2(DIV_W);

	localparam logic [1:0] CMD_ADVANCE = 2'd0;
	localparam logic [1:0] CMD_QUERY   = 2'd1;
	localparam logic [1:0] CMD_LOAD    = 2'd2;

	localparam logic CFG_FRAME_COUNT = 1'b0;
	localparam logic CFG_LOOP_LIMIT  = 1'b1;

	typedef enum logic [2:0] {
		DK_FWD  = 3'd0,
		DK_BWD  = 3'd1,
		DK_QNEG = 3'd2,
		DK_QPOS = 3'd3,
		DK_FRAC = 3'd4
	} div_kind_t;
endpackage

>>> rtl/core/keyframe_timeline_advance.sv
// Takes one word at a time: a new word is accepted only after the previous
// result has been taken. Advance and query walk the single-port frame table;
// each division (advance wrap, query wrap, query fraction) runs through the
// 48-step serial divider.
// Reset clears time, frames, loop count and the frame count register, sets
// the loop limit register to all ones (unlimited); the table is unset.
module keyframe_timeline_advance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic signed [31:0] elapsed_time,
	input  logic [16:0] interp_t,
	input  logic [5:0]  load_index,
	input  logic [30:0] load_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  current_frame,
	output logic [5:0]  next_frame,
	output logic [7:0]  loop_count,
	output logic signed [31:0] time_in_loop,
	output logic [5:0]  render_start_frame,
	output logic [5:0]  render_end_frame,
	output logic [16:0] render_fraction,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);
	localparam int IW = kta_pkg::IDX_W;
	localparam int DW = kta_pkg::DIV_W;

	typedef enum logic [16:0] {
		S_IDLE    = 17'h00001,
		S_LEN_RD  = 17'h00002,
		S_LEN_CHK = 17'h00004,
		S_DIV     = 17'h00008,
		S_DIV_END = 17'h00010,
		S_FWD_RD  = 17'h00020,
		S_FWD_CHK = 17'h00040,
		S_BWD_RD  = 17'h00080,
		S_BWD_CHK = 17'h00100,
		S_Q_MUL   = 17'h00200,
		S_Q_WRAP  = 17'h00400,
		S_Q_RD    = 17'h00800,
		S_Q_CHK   = 17'h01000,
		S_Q_ERD   = 17'h02000,
		S_Q_ECHK  = 17'h04000,
		S_Q_SCHK  = 17'h08000,
		S_Q_FRAC  = 17'h10000
	} state_t;

	state_t state_q;
	logic [30:0] mem [kta_pkg::MAX_FRAMES];
	logic [30:0] rd_data_q;
	logic [IW-1:0] rd_addr;

	logic [kta_pkg::CNT_W-1:0] frame_count_q;
	logic [8:0] loop_limit_q;
	logic [1:0] cmd_q;
	logic signed [31:0] step_q;
	logic [16:0] tin_q;
	logic [30:0] len_q;
	logic signed [33:0] t_q;
	logic [IW-1:0] fn_q, fa_q, sf_q, ef_q;
	logic [7:0] loops_q;
	logic signed [31:0] total_q, last_step_q;
	logic signed [49:0] prod_q;
	logic [30:0] endv_q, st_q;
	logic [16:0] frac_q;
	logic out_valid_q;

	logic [DW-1:0] div_num_q, div_quo_q;
	logic [31:0] div_den_q, div_rem_q;
	logic [kta_pkg::DIVC_W-1:0] div_cnt_q;
	kta_pkg::div_kind_t div_kind_q;

	logic [kta_pkg::CNT_W-1:0] cnt;
	logic [IW-1:0] last_idx;
	logic signed [33:0] tsum, len34, qs, den, num;
	logic [32:0] rem_sh;
	logic div_ge;
	logic [48:0] fk, bk;
	logic [kta_pkg::CNT_W-1:0] fn_inc, sf_inc;
	logic [17:0] wgt;
	logic in_acc;

	assign in_acc    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign cfg_ready = 1'b1;
	assign cnt = (frame_count_q > kta_pkg::CNT_W'(kta_pkg::MAX_FRAMES)) ?
		kta_pkg::CNT_W'(kta_pkg::MAX_FRAMES) : frame_count_q;
	assign last_idx = IW'(cnt - 1'b1);
	assign len34 = $signed({3'b0, len_q});
	assign tsum  = $signed({{2{total_q[31]}}, total_q}) + $signed({{2{step_q[31]}}, step_q});
	assign qs    = $signed({{2{total_q[31]}}, total_q}) - $signed(prod_q[49:16]);
	assign den   = $signed({3'b0, endv_q}) - $signed({3'b0, st_q});
	assign num   = t_q - $signed({3'b0, st_q});
	assign rem_sh = {div_rem_q, div_num_q[DW-1]};
	assign div_ge = rem_sh >= {1'b0, div_den_q};
	assign fk = 49'(div_quo_q) + 49'(loops_q);
	assign bk = 49'(div_quo_q) + 49'(div_rem_q != '0);
	assign fn_inc = kta_pkg::CNT_W'(fn_q) + 1'b1;
	assign sf_inc = kta_pkg::CNT_W'(sf_q) + 1'b1;
	assign wgt = {1'b0, 17'(kta_pkg::FRAC_ONE) - tin_q};

	always_comb begin
		unique case (state_q)
			S_LEN_RD: rd_addr = last_idx;
			S_BWD_RD: rd_addr = fn_q - 1'b1;
			S_Q_RD, S_Q_ERD: rd_addr = sf_q;
			S_Q_ECHK: rd_addr = sf_q - 1'b1;
			default: rd_addr = fn_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc && cmd == kta_pkg::CMD_LOAD)
			mem[load_index] <= load_value;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			loop_limit_q  <= '1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == kta_pkg::CFG_FRAME_COUNT)
				frame_count_q <= cfg_data[kta_pkg::CNT_W-1:0];
			else
				loop_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIV) begin
			div_rem_q <= div_ge ? 32'(rem_sh - {1'b0, div_den_q}) : rem_sh[31:0];
			div_num_q <= {div_num_q[DW-2:0], 1'b0};
			div_quo_q <= {div_quo_q[DW-2:0], div_ge};
		end else begin
			div_rem_q <= '0;
			div_quo_q <= '0;
			unique case (state_q)
				S_LEN_CHK: begin
					div_den_q <= {1'b0, rd_data_q};
					if (!step_q[31])
						div_num_q <= DW'(tsum - 34'sd1);
					else
						div_num_q <= DW'(-tsum);
				end
				S_Q_WRAP: begin
					div_den_q <= {1'b0, len_q};
					if (qs < 0)
						div_num_q <= DW'(-qs);
					else
						div_num_q <= DW'(qs - 34'sd1);
				end
				S_Q_FRAC: begin
					div_den_q <= 32'(den);
					div_num_q <= {num[31:0], 16'b0};
				end
				default: div_num_q <= div_num_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			fn_q        <= '0;
			fa_q        <= '0;
			loops_q     <= '0;
			total_q     <= '0;
			last_step_q <= '0;
			sf_q        <= '0;
			ef_q        <= '0;
			frac_q      <= '0;
			div_cnt_q   <= '0;
			div_kind_q  <= kta_pkg::DK_FWD;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q   <= cmd;
						step_q  <= elapsed_time;
						tin_q   <= (interp_t > 17'(kta_pkg::FRAC_ONE)) ?
							17'(kta_pkg::FRAC_ONE) : interp_t;
						sf_q    <= '0;
						ef_q    <= '0;
						frac_q  <= '0;
						state_q <= S_LEN_RD;
					end
				end
				S_LEN_RD: begin
					if ((cmd_q == kta_pkg::CMD_ADVANCE && cnt >= 7'd2) ||
							(cmd_q == kta_pkg::CMD_QUERY && cnt != '0)) begin
						state_q <= S_LEN_CHK;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_LEN_CHK: begin
					len_q     <= rd_data_q;
					div_cnt_q <= '0;
					if (rd_data_q == '0) begin
						if (cmd_q == kta_pkg::CMD_ADVANCE)
							last_step_q <= step_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (cmd_q == kta_pkg::CMD_QUERY) begin
						state_q <= S_Q_MUL;
					end else begin
						last_step_q <= step_q;
						t_q <= tsum;
						if (step_q == 0) begin
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							if (fn_q > last_idx)
								fn_q <= last_idx;
							if (!step_q[31]) begin
								div_kind_q <= kta_pkg::DK_FWD;
								state_q <= (tsum > $signed({3'b0, rd_data_q})) ?
									S_DIV : S_FWD_RD;
							end else begin
								div_kind_q <= kta_pkg::DK_BWD;
								state_q <= (tsum < 0) ? S_DIV : S_BWD_RD;
							end
						end
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == kta_pkg::DIVC_W'(DW - 1))
						state_q <= S_DIV_END;
				end
				S_DIV_END: begin
					case (div_kind_q)
						kta_pkg::DK_FWD: begin
							if (!loop_limit_q[8] && fk > 49'(loop_limit_q[7:0])) begin
								loops_q <= loop_limit_q[7:0];
								fn_q    <= last_idx;
								fa_q    <= last_idx;
								total_q <= {1'b0, len_q};
								out_valid_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								loops_q <= loop_limit_q[8] ? 8'hFF : fk[7:0];
								fn_q    <= '0;
								t_q     <= $signed({2'b0, div_rem_q}) + 34'sd1;
								state_q <= S_FWD_RD;
							end
						end
						kta_pkg::DK_BWD: begin
							if (bk > 49'(loops_q) && !loop_limit_q[8]) begin
								loops_q <= '0;
								fn_q    <= '0;
								fa_q    <= '0;
								total_q <= '0;
								out_valid_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								loops_q <= (bk > 49'(loops_q)) ? 8'd0 : loops_q - bk[7:0];
								fn_q    <= last_idx;
								fa_q    <= '0;
								t_q     <= (div_rem_q == '0) ? 34'sd0 :
									len34 - $signed({2'b0, div_rem_q});
								state_q <= S_BWD_RD;
							end
						end
						kta_pkg::DK_QNEG: begin
							t_q <= (div_rem_q == '0) ? 34'sd0 :
								len34 - $signed({2'b0, div_rem_q});
							state_q <= S_Q_RD;
						end
						kta_pkg::DK_QPOS: begin
							t_q     <= $signed({2'b0, div_rem_q}) + 34'sd1;
							state_q <= S_Q_RD;
						end
						default: begin
							frac_q      <= div_quo_q[16:0];
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					endcase
				end
				S_FWD_RD: begin
					if (fn_q < last_idx) begin
						state_q <= S_FWD_CHK;
					end else begin
						fa_q    <= (fn_inc >= cnt) ? '0 : IW'(fn_inc);
						total_q <= t_q[31:0];
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FWD_CHK: begin
					if (t_q > $signed({3'b0, rd_data_q})) begin
						fn_q    <= fn_q + 1'b1;
						state_q <= S_FWD_RD;
					end else begin
						fa_q    <= (fn_inc >= cnt) ? '0 : IW'(fn_inc);
						total_q <= t_q[31:0];
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_BWD_RD: begin
					if (fn_q != '0) begin
						state_q <= S_BWD_CHK;
					end else begin
						total_q <= t_q[31:0];
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_BWD_CHK: begin
					if (t_q < $signed({3'b0, rd_data_q})) begin
						fa_q    <= fn_q;
						fn_q    <= fn_q - 1'b1;
						state_q <= S_BWD_RD;
					end else begin
						total_q <= t_q[31:0];
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_Q_MUL: begin
					prod_q  <= last_step_q * $signed(wgt);
					state_q <= S_Q_WRAP;
				end
				S_Q_WRAP: begin
					sf_q <= '0;
					t_q  <= qs;
					if (qs < 0) begin
						div_kind_q <= kta_pkg::DK_QNEG;
						state_q    <= S_DIV;
					end else if (qs > len34) begin
						div_kind_q <= kta_pkg::DK_QPOS;
						state_q    <= S_DIV;
					end else begin
						state_q <= S_Q_RD;
					end
				end
				S_Q_RD: state_q <= (sf_q < last_idx) ? S_Q_CHK : S_Q_ERD;
				S_Q_CHK: begin
					if (t_q > $signed({3'b0, rd_data_q})) begin
						sf_q    <= sf_q + 1'b1;
						state_q <= S_Q_RD;
					end else begin
						state_q <= S_Q_ERD;
					end
				end
				S_Q_ERD: state_q <= S_Q_ECHK;
				S_Q_ECHK: begin
					endv_q <= rd_data_q;
					if (sf_q == '0) begin
						st_q    <= '0;
						state_q <= S_Q_FRAC;
					end else begin
						state_q <= S_Q_SCHK;
					end
				end
				S_Q_SCHK: begin
					st_q    <= rd_data_q;
					state_q <= S_Q_FRAC;
				end
				S_Q_FRAC: begin
					ef_q      <= (sf_inc >= cnt) ? '0 : IW'(sf_inc);
					div_cnt_q <= '0;
					if (den <= 0 || num <= 0) begin
						frac_q      <= '0;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (num >= den) begin
						frac_q      <= 17'(kta_pkg::FRAC_ONE);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						div_kind_q <= kta_pkg::DK_FRAC;
						state_q    <= S_DIV;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign current_frame      = fn_q;
	assign next_frame         = fa_q;
	assign loop_count         = loops_q;
	assign time_in_loop       = total_q;
	assign render_start_frame = sf_q;
	assign render_end_frame   = ef_q;
	assign render_fraction    = frac_q;
endmodule

>>> rtl/core/kta_checker.sv
`include "keyframe_timeline_advance_assert.svh"

module kta_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] render_fraction
);
	`KTA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`KTA_ASSERT_NOW(a_one_word, in_ready, !out_valid)
	`KTA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`KTA_ASSERT_NOW(a_frac_range, out_valid, render_fraction <= 17'(kta_pkg::FRAC_ONE))
endmodule

bind keyframe_timeline_advance kta_checker u_kta_checker (.*);

>>> tb/keyframe_timeline_advance_tb.sv
module keyframe_timeline_advance_tb;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 60000;
	localparam int SETTLE = 300;

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] step;
		logic [16:0]        tpos;
		logic [5:0]         idx;
		logic [30:0]        val;
	} word_t;

	typedef struct {
		logic [5:0]         cur;
		logic [5:0]         nxt;
		logic [7:0]         loops;
		logic signed [31:0] tloop;
		logic [5:0]         rs;
		logic [5:0]         re;
		logic [16:0]        rfrac;
	} frame_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = '0;
	logic signed [31:0] elapsed_time = '0;
	logic [16:0] interp_t = '0;
	logic [5:0] load_index = '0;
	logic [30:0] load_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] current_frame, next_frame, render_start_frame, render_end_frame;
	logic [7:0] loop_count;
	logic signed [31:0] time_in_loop;
	logic [16:0] render_fraction;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [8:0] cfg_data = '0;

	keyframe_timeline_advance dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// timeline mirror
	logic [30:0] end_time [kta_pkg::MAX_FRAMES];
	longint total_t, prev_step, limit_loops;
	int unsigned frame_cur, frame_nxt, loops_seen, frames_cfg;

	word_t pending_words [$];
	frame_state_t expected_states [$];
	word_t word_in_flight;
	int mismatches = 0, words_sent = 0, states_checked = 0, settings_used = 0;
	int send_gap = 0, recv_gap = 0, idle_cycles = 0;
	bit burst = 1'b0;

	// stimulus-side view of the table
	logic [30:0] gen_tab [kta_pkg::MAX_FRAMES];
	bit gen_written [kta_pkg::MAX_FRAMES];
	int gen_count = 0;

	function automatic longint sx32(longint v);
		return longint'($signed(v[31:0]));
	endfunction

	function automatic int unsigned frames_in_use();
		return frames_cfg > kta_pkg::MAX_FRAMES ? kta_pkg::MAX_FRAMES : frames_cfg;
	endfunction

	function automatic longint tab_at(int unsigned i);
		return longint'({1'b0, end_time[i % kta_pkg::MAX_FRAMES]});
	endfunction

	function automatic void advance_time(longint step);
		int unsigned cnt;
		longint len, t, k;
		cnt = frames_in_use();
		if (cnt < 2) return;
		len = tab_at(cnt - 1);
		prev_step = sx32(step);
		if (len <= 0 || step == 0) return;
		if (frame_cur > cnt - 1) frame_cur = cnt - 1;
		t = total_t + step;
		if (step > 0) begin
			if (t > len) begin
				k = (t - 1) / len;
				t -= k * len;
				if (limit_loops >= 0) begin
					if (longint'(loops_seen) + k > limit_loops) begin
						loops_seen = int'(limit_loops) & 8'hFF;
						frame_cur = cnt - 1;
						frame_nxt = frame_cur;
						total_t = sx32(len);
						return;
					end
					loops_seen = int'(longint'(loops_seen) + k) & 8'hFF;
				end else begin
					loops_seen = 8'hFF;
				end
				frame_cur = 0;
			end
			while (frame_cur < cnt - 1 && t > tab_at(frame_cur)) frame_cur++;
			frame_nxt = frame_cur + 1;
			if (frame_nxt >= cnt) frame_nxt = 0;
		end else begin
			if (t < 0) begin
				k = (-t + len - 1) / len;
				t += k * len;
				if (k > longint'(loops_seen)) begin
					loops_seen = 0;
					if (limit_loops >= 0) begin
						frame_cur = 0;
						frame_nxt = 0;
						total_t = 0;
						return;
					end
				end else begin
					loops_seen = int'(longint'(loops_seen) - k);
				end
				frame_cur = cnt - 1;
				frame_nxt = 0;
			end
			while (frame_cur > 0 && t < tab_at(frame_cur - 1)) begin
				frame_nxt = frame_cur;
				frame_cur--;
			end
		end
		total_t = sx32(t);
	endfunction

	function automatic void render_point(longint tin, ref frame_state_t r);
		int unsigned cnt, f;
		longint len, prod, share, s, st, den, num;
		cnt = frames_in_use();
		f = 0;
		if (cnt == 0) return;
		len = tab_at(cnt - 1);
		if (len <= 0) return;
		if (tin > kta_pkg::FRAC_ONE) tin = kta_pkg::FRAC_ONE;
		prod = prev_step * (kta_pkg::FRAC_ONE - tin);
		share = prod >= 0 ? prod / 65536 : -((-prod + 65535) / 65536);
		s = total_t - share;
		if (s < 0) s += ((-s + len - 1) / len) * len;
		if (s > len) s -= ((s - 1) / len) * len;
		while (f < cnt - 1 && s > tab_at(f)) f++;
		r.rs = 6'(f);
		r.re = (f + 1 >= cnt) ? 6'd0 : 6'(f + 1);
		st = (f == 0) ? 0 : tab_at(f - 1);
		den = tab_at(f) - st;
		num = s - st;
		if (den <= 0 || num <= 0) r.rfrac = '0;
		else if (num >= den) r.rfrac = 17'(kta_pkg::FRAC_ONE);
		else r.rfrac = 17'((num << 16) / den);
	endfunction

	function automatic void apply_word(word_t w);
		frame_state_t r;
		r.rs = 0;
		r.re = 0;
		r.rfrac = 0;
		case (w.op)
			kta_pkg::CMD_ADVANCE: advance_time(longint'(w.step));
			kta_pkg::CMD_QUERY:   render_point(longint'(w.tpos), r);
			kta_pkg::CMD_LOAD:    end_time[w.idx] = w.val;
			default: ;
		endcase
		r.cur = frame_cur[5:0];
		r.nxt = frame_nxt[5:0];
		r.loops = loops_seen[7:0];
		r.tloop = total_t[31:0];
		expected_states.push_back(r);
		words_sent++;
	endfunction

	task automatic report(string what, longint got, longint want);
		mismatches++;
		$display("  state %0d: %s got %0d want %0d", states_checked, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) apply_word(word_in_flight);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					word_in_flight = pending_words.pop_front();
					cmd <= word_in_flight.op;
					elapsed_time <= word_in_flight.step;
					interp_t <= word_in_flight.tpos;
					load_index <= word_in_flight.idx;
					load_value <= word_in_flight.val;
					in_valid <= 1'b1;
					send_gap = burst ? 0 : $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		frame_state_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				states_checked++;
				if (expected_states.size() == 0) begin
					report("unexpected word", 0, 0);
				end else begin
					e = expected_states.pop_front();
					if (current_frame !== e.cur) report("current_frame", current_frame, e.cur);
					if (next_frame !== e.nxt) report("next_frame", next_frame, e.nxt);
					if (loop_count !== e.loops) report("loop_count", loop_count, e.loops);
					if (time_in_loop !== e.tloop)
						report("time_in_loop", time_in_loop, e.tloop);
					if (render_start_frame !== e.rs)
						report("render_start_frame", render_start_frame, e.rs);
					if (render_end_frame !== e.re)
						report("render_end_frame", render_end_frame, e.re);
					if (render_fraction !== e.rfrac)
						report("render_fraction", render_fraction, e.rfrac);
				end
				recv_gap = burst ? 0 : $urandom_range(0, 3);
			end
			if (recv_gap != 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic push_word(logic [1:0] op, logic signed [31:0] step, logic [16:0] tpos,
			logic [5:0] idx, logic [30:0] val);
		word_t w;
		w.op = op;
		w.step = step;
		w.tpos = tpos;
		w.idx = idx;
		w.val = val;
		if (op == kta_pkg::CMD_LOAD) begin
			gen_tab[idx] = val;
			gen_written[idx] = 1'b1;
		end
		pending_words.push_back(w);
	endtask

	task automatic push_load(int i, logic [30:0] val);
		push_word(kta_pkg::CMD_LOAD, $urandom, 17'($urandom), i[5:0], val);
	endtask

	task automatic build_table();
		longint acc;
		int n;
		n = gen_count > kta_pkg::MAX_FRAMES ? kta_pkg::MAX_FRAMES : gen_count;
		acc = 0;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: acc += 0;
				1: acc += $urandom_range(1, 16);
				default: acc += $urandom_range(1, 32'h30000);
			endcase
			push_load(i, acc[30:0]);
		end
	endtask

	task automatic push_random_word();
		int n, pick;
		longint len, mag;
		n = gen_count > kta_pkg::MAX_FRAMES ? kta_pkg::MAX_FRAMES : gen_count;
		len = n > 0 ? longint'(gen_tab[n - 1]) : 0;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			n = $urandom_range(0, 63);
			if ($urandom_range(0, 1))
				push_load(n, 31'($urandom));
			else
				push_load(n, (n == 0 || !gen_written[n - 1]) ?
					31'($urandom_range(0, 32'h20000)) :
					31'(longint'(gen_tab[n - 1]) + $urandom_range(0, 32'h20000)));
		end else if (pick < 12) begin
			push_word(CMD_UNUSED, $urandom, 17'($urandom), 6'($urandom), 31'($urandom));
		end else if (pick < 40) begin
			push_word(kta_pkg::CMD_QUERY, $urandom, $urandom_range(0, 4) == 0 ?
				17'($urandom) : 17'($urandom_range(0, kta_pkg::FRAC_ONE)),
				6'($urandom), 31'($urandom));
		end else begin
			case ($urandom_range(0, 9))
				0: mag = longint'($signed($urandom));
				1: mag = 0;
				2, 3, 4, 5: mag = $urandom_range(1, int'(len / 4) + 1);
				6, 7, 8: mag = $urandom_range(1, int'((len > 32'h2AAAAAAA ?
					32'h2AAAAAAA : len) * 3) + 1);
				default: mag = len;
			endcase
			if ($urandom_range(0, 99) < 35) mag = -mag;
			push_word(kta_pkg::CMD_ADVANCE, 32'(mag), 17'($urandom), 6'($urandom),
				31'($urandom));
		end
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || in_valid || expected_states.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic which, logic [8:0] data);
		cfg_index <= which;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (which == kta_pkg::CFG_FRAME_COUNT) frames_cfg = data[6:0];
		else limit_loops = longint'($signed(data));
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(int frames, int lim);
		drain();
		write_reg(kta_pkg::CFG_FRAME_COUNT, 9'(frames));
		@(posedge clk);
		write_reg(kta_pkg::CFG_LOOP_LIMIT, 9'(lim));
		gen_count = frames;
		settings_used++;
		burst = $urandom_range(0, 2) == 0;
	endtask

	initial begin
		int frames_list [8] = '{64, 2, 127, 8, 1, 16, 3, 33};
		int limit_list [8] = '{254, 0, -1, 2, 3, -256, 255, 1};
		total_t = 0;
		prev_step = 0;
		frame_cur = 0;
		frame_nxt = 0;
		loops_seen = 0;
		frames_cfg = 0;
		limit_loops = -1;
		foreach (gen_written[i]) gen_written[i] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// no frames: queries answer zero, advances do nothing
		push_word(kta_pkg::CMD_QUERY, 0, 17'(kta_pkg::FRAC_ONE), 0, 0);
		push_word(kta_pkg::CMD_ADVANCE, 32'h0001_0000, 0, 0, 0);
		push_word(CMD_UNUSED, '1, '1, '1, '1);
		for (int i = 0; i < 4; i++) push_load(i, 0);
		push_load(63, 31'h7FFF_FFFF);

		// zero-length timeline
		set_regs(4, -1);
		push_word(kta_pkg::CMD_ADVANCE, 32'h0002_0000, 0, 0, 0);
		push_word(kta_pkg::CMD_QUERY, 0, 0, 0, 0);
		push_load(0, 31'h0001_0000);
		push_load(1, 31'h0001_0000);
		push_load(2, 31'h0003_0000);
		push_load(3, 31'h0004_0000);
		push_word(kta_pkg::CMD_ADVANCE, 32'h0000_8000, 0, 0, 0);
		push_word(kta_pkg::CMD_QUERY, 0, 17'd32768, 0, 0);
		push_word(kta_pkg::CMD_ADVANCE, 0, 0, 0, 0);
		push_word(kta_pkg::CMD_ADVANCE, 32'h7FFF_FFFF, 0, 0, 0);
		push_word(kta_pkg::CMD_QUERY, 0, 17'(kta_pkg::FRAC_ONE), 0, 0);
		push_word(kta_pkg::CMD_QUERY, 0, 17'h1FFFF, 0, 0);
		push_word(kta_pkg::CMD_ADVANCE, 32'h8000_0000, 0, 0, 0);
		push_word(kta_pkg::CMD_ADVANCE, -32'sh0001_8000, 0, 0, 0);
		push_word(kta_pkg::CMD_QUERY, 0, 0, 0, 0);
		for (int i = 0; i < 200; i++) push_random_word();

		foreach (frames_list[p]) begin
			set_regs(frames_list[p], limit_list[p]);
			build_table();
			for (int i = 0; i < 170; i++) push_random_word();
		end
		drain();
		$display("%0d words over %0d register settings, %0d result words compared",
			words_sent, settings_used, states_checked);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
